### hw/rtl/assert_macros.svh
// assertion macros used by the scheduler core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check that is off while reset is asserted
`define CBRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked check that also holds during reset
`define CBRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/cbrs_pkg.sv
// types and constants of the capped backoff retry scheduler
`timescale 1ns / 1ps

package cbrs_pkg;

    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 16;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0]  DEFAULT_FIRST_DELAY   = 32'd500;
    localparam logic [TIME_W-1:0]  DEFAULT_DELAY_CEILING = 32'd30000;
    localparam logic [TIME_W-1:0]  SIGN_LIMIT            = 32'h8000_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX             = 16'hFFFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_QUERY = 2'd0,
        ACT_FAIL  = 2'd1,
        ACT_RESET = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_DELAY   = 2'd0,
        CFG_DELAY_CEILING = 2'd1,
        CFG_ATTEMPT_LIMIT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0]  first_delay;
        logic [TIME_W-1:0]  delay_ceiling;
        logic [COUNT_W-1:0] attempt_limit;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  scheduled_time;
        logic [COUNT_W-1:0] attempts_made;
        logic               due;
        logic               exhausted;
    } result_t;

endpackage

### hw/rtl/cbrs_ifs.sv
// valid/ready channel interfaces of the retry scheduler
`timescale 1ns / 1ps

interface cbrs_in_if;
    logic                          valid;
    logic                          ready;
    logic [cbrs_pkg::ACTION_W-1:0] action;
    logic [cbrs_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, action, now_ms, input ready);
    modport sink (input valid, action, now_ms, output ready);
endinterface

interface cbrs_out_if;
    logic                         valid;
    logic                         ready;
    logic [cbrs_pkg::TIME_W-1:0]  scheduled_time;
    logic [cbrs_pkg::COUNT_W-1:0] attempts_made;
    logic                         due;
    logic                         exhausted;

    modport source (output valid, scheduled_time, attempts_made, due, exhausted, input ready);
    modport sink (input valid, scheduled_time, attempts_made, due, exhausted, output ready);
endinterface

interface cbrs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cbrs_pkg::CFG_IDX_W-1:0] index;
    logic [cbrs_pkg::TIME_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/cbrs_cfg.sv
// configuration registers, stored as effective values with defaults applied
`timescale 1ns / 1ps

module cbrs_cfg (
    input  logic            clk,
    input  logic            rst_n,
    cbrs_cfg_if.sink        cfg,
    output cbrs_pkg::cfg_t  settings
);

    logic [cbrs_pkg::TIME_W-1:0]  first_delay_reg;
    logic [cbrs_pkg::TIME_W-1:0]  delay_ceiling_reg;
    logic [cbrs_pkg::COUNT_W-1:0] attempt_limit_reg;
    logic                         wr_fire;

    assign cfg.ready = 1'b1;
    assign wr_fire   = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg   <= cbrs_pkg::DEFAULT_FIRST_DELAY;
            delay_ceiling_reg <= cbrs_pkg::DEFAULT_DELAY_CEILING;
            attempt_limit_reg <= '0;
        end
        else if (wr_fire)
        begin
            unique case (cfg.index)
                cbrs_pkg::CFG_FIRST_DELAY:
                begin
                    first_delay_reg <= (cfg.data == '0) ?
                        cbrs_pkg::DEFAULT_FIRST_DELAY : cfg.data;
                end
                cbrs_pkg::CFG_DELAY_CEILING:
                begin
                    delay_ceiling_reg <= (cfg.data == '0) ?
                        cbrs_pkg::DEFAULT_DELAY_CEILING : cfg.data;
                end
                cbrs_pkg::CFG_ATTEMPT_LIMIT:
                begin
                    attempt_limit_reg <= cfg.data[cbrs_pkg::COUNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign settings.first_delay   = first_delay_reg;
    assign settings.delay_ceiling = delay_ceiling_reg;
    assign settings.attempt_limit = attempt_limit_reg;

endmodule

### hw/rtl/cbrs_engine.sv
// retry state and single-pass backoff update
`timescale 1ns / 1ps

module cbrs_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [cbrs_pkg::ACTION_W-1:0] action,
    input  logic [cbrs_pkg::TIME_W-1:0]   now_ms,
    input  cbrs_pkg::cfg_t                settings,
    output cbrs_pkg::result_t             result
);

    logic [cbrs_pkg::COUNT_W-1:0] attempt_count_reg;
    logic [cbrs_pkg::COUNT_W-1:0] attempt_count_next;
    logic [cbrs_pkg::TIME_W-1:0]  current_delay_reg;
    logic [cbrs_pkg::TIME_W-1:0]  current_delay_next;
    logic [cbrs_pkg::TIME_W-1:0]  next_time_reg;
    logic [cbrs_pkg::TIME_W-1:0]  next_time_next;
    logic                         waiting_reg;
    logic                         waiting_next;

    logic [cbrs_pkg::TIME_W-1:0]  ceil_val;
    logic [cbrs_pkg::TIME_W-1:0]  first_pick;
    logic [cbrs_pkg::TIME_W-1:0]  doubled;
    logic [cbrs_pkg::TIME_W-1:0]  doubled_pick;
    logic [cbrs_pkg::TIME_W-1:0]  grown;
    logic [cbrs_pkg::TIME_W-1:0]  fail_delay;
    logic [cbrs_pkg::TIME_W-1:0]  fail_time;
    logic [cbrs_pkg::TIME_W-1:0]  query_diff;
    logic [cbrs_pkg::COUNT_W-1:0] count_inc;
    logic                         due_now;

    always_comb
    begin
        ceil_val     = settings.delay_ceiling;
        first_pick   = (settings.first_delay < ceil_val) ? settings.first_delay : ceil_val;
        doubled      = {current_delay_reg[cbrs_pkg::TIME_W-2:0], 1'b0};
        doubled_pick = (doubled < ceil_val) ? doubled : ceil_val;
        // doubling overflows once the top bit is set
        grown        = ((current_delay_reg >= ceil_val) ||
                        current_delay_reg[cbrs_pkg::TIME_W-1]) ? ceil_val : doubled_pick;
        fail_delay   = (attempt_count_reg == '0) ? first_pick : grown;
        fail_time    = now_ms + fail_delay;
        query_diff   = now_ms - next_time_reg;
        count_inc    = (attempt_count_reg == cbrs_pkg::COUNT_MAX) ?
                       attempt_count_reg : attempt_count_reg + 16'd1;

        attempt_count_next = attempt_count_reg;
        current_delay_next = current_delay_reg;
        next_time_next     = next_time_reg;
        waiting_next       = waiting_reg;
        due_now            = !waiting_reg || !query_diff[cbrs_pkg::TIME_W-1];

        unique case (action)
            cbrs_pkg::ACT_FAIL:
            begin
                attempt_count_next = count_inc;
                current_delay_next = fail_delay;
                next_time_next     = fail_time;
                waiting_next       = 1'b1;
                // now minus (now plus delay) is the negated delay
                due_now            = (fail_delay == '0) || (fail_delay > cbrs_pkg::SIGN_LIMIT);
            end
            cbrs_pkg::ACT_RESET:
            begin
                attempt_count_next = '0;
                next_time_next     = '0;
                waiting_next       = 1'b0;
                due_now            = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_count_reg <= '0;
            current_delay_reg <= '0;
            next_time_reg     <= '0;
            waiting_reg       <= 1'b0;
        end
        else if (fire)
        begin
            attempt_count_reg <= attempt_count_next;
            current_delay_reg <= current_delay_next;
            next_time_reg     <= next_time_next;
            waiting_reg       <= waiting_next;
        end
    end

    assign result.scheduled_time = next_time_next;
    assign result.attempts_made  = attempt_count_next;
    assign result.due            = due_now;
    assign result.exhausted      = (settings.attempt_limit != '0) &&
                                   (attempt_count_next >= settings.attempt_limit);

endmodule

### hw/rtl/capped_backoff_retry_scheduler_core.sv
// Capped exponential backoff retry scheduler: one transaction is accepted per clock
// cycle while the result register is free or being taken; each result passes the input
// register, then the result register, and a stalled result holds the input register;
// throughput is set by the state update loop (delay select and time add)
// in the engine. Configuration writes are always ready and take effect at once; no
// clearing pass follows reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module capped_backoff_retry_scheduler_core (
    input  logic        clk,
    input  logic        rst_n,
    cbrs_in_if.sink     req,
    cbrs_out_if.source  rsp,
    cbrs_cfg_if.sink    cfg
);

    logic                          s1_valid_reg;
    logic [cbrs_pkg::ACTION_W-1:0] s1_action_reg;
    logic [cbrs_pkg::TIME_W-1:0]   s1_now_reg;
    logic                          out_valid_reg;
    cbrs_pkg::result_t             out_result_reg;
    cbrs_pkg::result_t             result;
    cbrs_pkg::cfg_t                settings;
    logic                          advance;

    cbrs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    cbrs_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .action   (s1_action_reg),
        .now_ms   (s1_now_reg),
        .settings (settings),
        .result   (result)
    );

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_action_reg <= req.action;
            s1_now_reg    <= req.now_ms;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.scheduled_time = out_result_reg.scheduled_time;
    assign rsp.attempts_made  = out_result_reg.attempts_made;
    assign rsp.due            = out_result_reg.due;
    assign rsp.exhausted      = out_result_reg.exhausted;

    // exhaustion needs a nonzero limit, so at least one failure
    `CBRS_ASSERT(a_exhausted_has_attempts, clk, rst_n,
        rsp.valid && rsp.exhausted |-> rsp.attempts_made != '0, "exhausted with no attempts")
    // no attempts means nothing is waiting
    `CBRS_ASSERT(a_idle_is_due, clk, rst_n,
        rsp.valid && rsp.attempts_made == '0 |-> rsp.due, "not due with no attempts")
    // a stalled result keeps the input stage full
    `CBRS_ASSERT(a_stall_holds_stage, clk, rst_n,
        s1_valid_reg && out_valid_reg && !rsp.ready |=> s1_valid_reg,
        "input stage lost under stall")
    `CBRS_ASSERT_ALWAYS(a_reset_empty, clk,
        !rst_n |=> !out_valid_reg && !s1_valid_reg, "pipeline not empty in reset")

endmodule

### bench/tb_top.sv
// self-checking testbench of the capped backoff retry scheduler core
`timescale 1ns / 1ps

module tb_top;

    localparam logic [cbrs_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 110;

    logic clk;
    logic rst_n;

    cbrs_in_if  in_ch ();
    cbrs_out_if out_ch ();
    cbrs_cfg_if cfg_ch ();

    capped_backoff_retry_scheduler_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_ch),
        .rsp   (out_ch),
        .cfg   (cfg_ch)
    );

    // register copy
    logic [cbrs_pkg::TIME_W-1:0]  cf_first   = cbrs_pkg::DEFAULT_FIRST_DELAY;
    logic [cbrs_pkg::TIME_W-1:0]  cf_ceiling = cbrs_pkg::DEFAULT_DELAY_CEILING;
    logic [cbrs_pkg::COUNT_W-1:0] cf_limit   = '0;

    // retry state copy
    logic [cbrs_pkg::COUNT_W-1:0] bk_count   = '0;
    logic [cbrs_pkg::TIME_W-1:0]  bk_delay   = '0;
    logic [cbrs_pkg::TIME_W-1:0]  bk_next    = '0;
    logic                         bk_waiting = 1'b0;

    cbrs_pkg::result_t           sched_expected[$];
    logic [cbrs_pkg::TIME_W-1:0] clock_ms = '0;
    int                          errors = 0;
    int                          src_idle_pct = 0;
    int                          snk_idle_pct = 0;
    int                          stall_cycles = 0;
    int                          hold_left = 0;
    bit                          hold_req = 1'b0;
    bit                          hold_ack = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cbrs_pkg::result_t backoff_result(
        input logic [cbrs_pkg::ACTION_W-1:0] act,
        input logic [cbrs_pkg::TIME_W-1:0] now);
        cbrs_pkg::result_t           r;
        logic [cbrs_pkg::TIME_W-1:0] first_eff;
        logic [cbrs_pkg::TIME_W-1:0] ceil_eff;
        logic [cbrs_pkg::TIME_W-1:0] gap;
        first_eff = (cf_first != '0) ? cf_first : cbrs_pkg::DEFAULT_FIRST_DELAY;
        ceil_eff  = (cf_ceiling != '0) ? cf_ceiling : cbrs_pkg::DEFAULT_DELAY_CEILING;
        if (act == cbrs_pkg::ACT_FAIL)
        begin
            if (bk_count == '0)
                bk_delay = (first_eff < ceil_eff) ? first_eff : ceil_eff;
            else if (bk_delay >= ceil_eff || bk_delay > ~bk_delay)
                bk_delay = ceil_eff;
            else
                bk_delay = ((bk_delay << 1) < ceil_eff) ? (bk_delay << 1) : ceil_eff;
            if (bk_count != cbrs_pkg::COUNT_MAX)
                bk_count = bk_count + 1'b1;
            bk_next    = now + bk_delay;
            bk_waiting = 1'b1;
        end
        else if (act == cbrs_pkg::ACT_RESET)
        begin
            bk_count   = '0;
            bk_next    = '0;
            bk_waiting = 1'b0;
        end
        gap = now - bk_next;
        r.scheduled_time = bk_next;
        r.attempts_made  = bk_count;
        r.due            = !bk_waiting || !gap[cbrs_pkg::TIME_W-1];
        r.exhausted      = (cf_limit != '0) && (bk_count >= cf_limit);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic check_result();
        cbrs_pkg::result_t want;
        if (sched_expected.size() == 0)
        begin
            note_failure($sformatf("unexpected result: time %h count %0d due %b exh %b",
                out_ch.scheduled_time, out_ch.attempts_made, out_ch.due, out_ch.exhausted));
        end
        else
        begin
            want = sched_expected.pop_front();
            if (out_ch.scheduled_time !== want.scheduled_time
                || out_ch.attempts_made !== want.attempts_made
                || out_ch.due !== want.due
                || out_ch.exhausted !== want.exhausted)
            begin
                note_failure($sformatf(
                    "mismatch: exp time %h count %0d due %b exh %b, got %h %0d %b %b",
                    want.scheduled_time, want.attempts_made, want.due, want.exhausted,
                    out_ch.scheduled_time, out_ch.attempts_made, out_ch.due,
                    out_ch.exhausted));
            end
        end
    endtask

    // result sink with random stalls and long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            check_result();
        if (hold_req != hold_ack)
        begin
            hold_ack     <= hold_req;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_item(input logic [cbrs_pkg::ACTION_W-1:0] act,
                             input logic [cbrs_pkg::TIME_W-1:0] now);
        cbrs_pkg::result_t want;
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.now_ms <= now;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        want = backoff_result(act, now);
        sched_expected.push_back(want);
        clock_ms = now;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (sched_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cbrs_pkg::cfg_index_t idx,
                             input logic [cbrs_pkg::TIME_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            cbrs_pkg::CFG_FIRST_DELAY:   cf_first = value;
            cbrs_pkg::CFG_DELAY_CEILING: cf_ceiling = value;
            cbrs_pkg::CFG_ATTEMPT_LIMIT: cf_limit = value[cbrs_pkg::COUNT_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [cbrs_pkg::TIME_W-1:0] first,
                              input logic [cbrs_pkg::TIME_W-1:0] ceiling,
                              input logic [cbrs_pkg::COUNT_W-1:0] limit);
        wait_idle();
        write_reg(cbrs_pkg::CFG_FIRST_DELAY, first);
        write_reg(cbrs_pkg::CFG_DELAY_CEILING, ceiling);
        write_reg(cbrs_pkg::CFG_ATTEMPT_LIMIT,
                  {{(cbrs_pkg::TIME_W-cbrs_pkg::COUNT_W){1'b0}}, limit});
    endtask

    task automatic send_random_item();
        logic [cbrs_pkg::ACTION_W-1:0] act;
        logic [cbrs_pkg::TIME_W-1:0]   now;
        int                            pick;
        pick = $urandom_range(99);
        if (pick < 45)
            act = cbrs_pkg::ACT_FAIL;
        else if (pick < 80)
            act = cbrs_pkg::ACT_QUERY;
        else if (pick < 92)
            act = cbrs_pkg::ACT_RESET;
        else
            act = ACT_SPARE;
        pick = $urandom_range(99);
        if (pick < 50)
            now = bk_next + $urandom_range(40) - 20;
        else if (pick < 85)
            now = clock_ms + $urandom_range(5000);
        else
            now = $urandom();
        send_item(act, now);
    endtask

    task automatic test_default_schedule();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_item(cbrs_pkg::ACT_QUERY, 32'd0);
        send_item(cbrs_pkg::ACT_FAIL, 32'd1000);
        send_item(cbrs_pkg::ACT_QUERY, 32'd1499);
        send_item(cbrs_pkg::ACT_QUERY, 32'd1500);
        // doubling up to the ceiling and staying there
        repeat (7) send_item(cbrs_pkg::ACT_FAIL, 32'd1500);
        send_item(ACT_SPARE, 32'hFFFF_FFFF);
        send_item(cbrs_pkg::ACT_RESET, 32'd0);
        // schedule wraps past zero
        send_item(cbrs_pkg::ACT_FAIL, 32'hFFFF_FF00);
        send_item(cbrs_pkg::ACT_QUERY, 32'hFFFF_FFFF);
        send_item(cbrs_pkg::ACT_QUERY, 32'h0000_00F4);
        send_item(cbrs_pkg::ACT_QUERY, 32'h0000_00F4 + cbrs_pkg::SIGN_LIMIT);
        send_item(cbrs_pkg::ACT_QUERY, 32'h0000_00F3 + cbrs_pkg::SIGN_LIMIT);
        send_item(cbrs_pkg::ACT_RESET, 32'h8000_0000);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        set_config(32'd0, 32'hFFFF_FFFF, 16'd1);
        send_item(cbrs_pkg::ACT_RESET, 32'd0);
        send_item(cbrs_pkg::ACT_FAIL, 32'd0);
        send_item(cbrs_pkg::ACT_FAIL, 32'd10);
        // doubling overflow gives the ceiling
        set_config(32'h9000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(cbrs_pkg::ACT_RESET, 32'd5);
        repeat (3) send_item(cbrs_pkg::ACT_FAIL, 32'h7000_0000);
        // first delay above the ceiling is clamped
        set_config(32'hFFFF_FFFF, 32'd300, 16'd2);
        send_item(cbrs_pkg::ACT_RESET, 32'd0);
        send_item(cbrs_pkg::ACT_FAIL, 32'd100);
        send_item(cbrs_pkg::ACT_FAIL, 32'd200);
        // ceiling change keeps the current delay
        set_config(32'd7, 32'd0, 16'd0);
        send_item(cbrs_pkg::ACT_FAIL, 32'd300);
        send_item(cbrs_pkg::ACT_RESET, 32'd400);
        send_item(cbrs_pkg::ACT_FAIL, 32'd500);
        send_item(cbrs_pkg::ACT_FAIL, 32'd600);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
        logic [cbrs_pkg::TIME_W-1:0]  first;
        logic [cbrs_pkg::TIME_W-1:0]  ceiling;
        logic [cbrs_pkg::COUNT_W-1:0] limit;
        case ($urandom_range(3))
            0: first = '0;
            1: first = $urandom_range(2000, 1);
            2: first = $urandom();
            default: first = 32'd1;
        endcase
        case ($urandom_range(3))
            0: ceiling = '0;
            1: ceiling = $urandom_range(100000, 1);
            2: ceiling = $urandom();
            default: ceiling = 32'hFFFF_FFFF;
        endcase
        case ($urandom_range(3))
            0: limit = '0;
            3: limit = 16'($urandom_range(65535));
            default: limit = 16'($urandom_range(8, 1));
        endcase
        set_config(first, ceiling, limit);
        src_idle_pct = snd_pct;
        snk_idle_pct = rcv_pct;
        repeat (PHASE_ITEMS) send_random_item();
        wait_idle();
    endtask

    task automatic test_backpressure();
        wait_idle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req <= ~hold_req;
        repeat (40) send_random_item();
        wait_idle();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.action  = cbrs_pkg::ACT_QUERY;
        in_ch.now_ms  = '0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = cbrs_pkg::CFG_FIRST_DELAY;
        cfg_ch.data   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_schedule();
        test_register_extremes();
        test_random_traffic(8, 56);
        test_random_traffic(56, 8);
        test_random_traffic(0, 0);
        test_backpressure();

        if (sched_expected.size() != 0)
            note_failure($sformatf("%0d results never arrived", sched_expected.size()));
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/cbrs_pkg.sv
hw/rtl/cbrs_ifs.sv
hw/rtl/cbrs_cfg.sv
hw/rtl/cbrs_engine.sv
hw/rtl/capped_backoff_retry_scheduler_core.sv
bench/tb_top.sv
